FILE: rtl/tdwq_pkg.sv
// Package for the tick delay wakeup queue: field widths, command and
// operation codes, the front-to-back operation record and the back FSM states.
// No dependencies.
`timescale 1ns / 1ps

package tdwq_pkg;

  localparam int TASK_W      = 5;
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 31;
  localparam int MAX_SLOTS   = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
  localparam logic [VALUE_W-1:0] REJECT_VALUE = 32'hFFFF_FFFE;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_DELAY = 2'd2,
    CMD_UNTIL = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_REPLY = 2'd0,
    OP_ARM   = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    BS_IDLE = 2'd0,
    BS_SCAN = 2'd1,
    BS_EMIT = 2'd2
  } bstate_e;

  // One classified request. For a reply, value is the reply value; for an arm,
  // value holds the wake time; for a tick, value is the new count and aux the
  // count before the tick.
  typedef struct packed {
    op_e                kind;
    logic [TASK_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] aux;
  } op_t;

endpackage

FILE: rtl/tdwq_cmd_if.sv
// Request channel of the tick delay wakeup queue (valid/ready plus payload).
// Depends on tdwq_pkg.
`timescale 1ns / 1ps

interface tdwq_cmd_if import tdwq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic [TASK_W-1:0]         requester;
  logic signed [VALUE_W-1:0] tick_amount;

  modport source (output valid, output command, output requester, output tick_amount,
                  input ready);
  modport sink   (input valid, input command, input requester, input tick_amount,
                  output ready);
endinterface

FILE: rtl/tdwq_rsp_if.sv
// Reply channel of the tick delay wakeup queue (valid/ready plus payload).
// Depends on tdwq_pkg.
`timescale 1ns / 1ps

interface tdwq_rsp_if import tdwq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [TASK_W-1:0]         reply_task;
  logic signed [VALUE_W-1:0] reply_value;
  logic                      last_of_run;

  modport source (output valid, output reply_task, output reply_value, output last_of_run,
                  input ready);
  modport sink   (input valid, input reply_task, input reply_value, input last_of_run,
                  output ready);
endinterface

FILE: rtl/tick_delay_wakeup_queue_unit.sv
// Tick delay wakeup queue, top level. Read-time and rejected requests reply
// through the queue and the back end's output register; delay requests only arm
// a slot. A tick scans the N slots of the wake time RAM (one read per cycle),
// then sends one reply each to the sender and to every released slot.
// Reset clears the tick count, all pending flags and the queue; the wake time
// RAM needs no clearing since it is only read behind a set pending flag.
`timescale 1ns / 1ps

module tick_delay_wakeup_queue_unit import tdwq_pkg::*; #(
  parameter int TASK_SLOTS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdwq_cmd_if.sink   cmd_i,
  tdwq_rsp_if.source rsp_o
);

  // The front end owns the tick count, so every request is classified against
  // the count as it stands after all earlier accepted requests. Ticks, arms
  // and immediate replies then pass through a short queue to the back end,
  // which keeps them in order.
  logic push_valid, push_ready;
  op_t  push_op;
  logic pop_valid, pop_ready;
  op_t  pop_op;

  tdwq_front #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_op_o   (push_op)
  );

  tdwq_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_op_i   (push_op),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_op_o    (pop_op)
  );

  // The back end sorts releases in one scan: slots due at the count before
  // the tick go first, then those due at the new count, each group in
  // ascending slot order. Its output register lets a queued arm or tick
  // proceed while a reply still waits to be taken.
  tdwq_back #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_valid_i(pop_valid),
    .op_ready_o(pop_ready),
    .op_i      (pop_op),
    .rsp_o     (rsp_o)
  );

endmodule

FILE: rtl/tdwq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tdwq_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tdwq_front.sv
// Front end: accepts requests, owns the tick count and turns each request
// into a reply, arm or tick operation for the back end. Depends on tdwq_pkg.
`timescale 1ns / 1ps

module tdwq_front import tdwq_pkg::*; #(
  parameter int TASK_SLOTS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tdwq_cmd_if.sink  cmd_i,
  output logic      push_valid_o,
  input  logic      push_ready_i,
  output op_t       push_op_o
);

  logic [COUNT_W-1:0] count_q, count_d;

  assign cmd_i.ready  = push_ready_i;
  assign push_valid_o = cmd_i.valid;

  always_comb begin
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] amount;
    logic [VALUE_W-1:0] sum;
    logic [COUNT_W-1:0] wake_rel;
    logic               neg;
    logic               slot_ok;

    count_next = (count_q != COUNT_MAX) ? count_q + 31'd1 : count_q;
    amount     = cmd_i.tick_amount[COUNT_W-1:0];
    neg        = cmd_i.tick_amount[VALUE_W-1];
    sum        = {1'b0, count_q} + {1'b0, amount};
    wake_rel   = sum[VALUE_W-1] ? COUNT_MAX : sum[COUNT_W-1:0];
    slot_ok    = (int'(cmd_i.requester) < TASK_SLOTS);

    count_d         = count_q;
    push_op_o.slot  = cmd_i.requester;
    push_op_o.aux   = count_q;
    push_op_o.kind  = OP_REPLY;
    push_op_o.value = {1'b0, count_q};

    unique case (cmd_e'(cmd_i.command))
      CMD_TICK: begin
        push_op_o.kind  = OP_TICK;
        push_op_o.value = {1'b0, count_next};
        if (cmd_i.valid && push_ready_i) begin
          count_d = count_next;
        end
      end
      CMD_READ: begin
        push_op_o.kind = OP_REPLY;
      end
      CMD_DELAY: begin
        if (neg || !slot_ok) begin
          push_op_o.value = REJECT_VALUE;
        end else begin
          push_op_o.kind  = OP_ARM;
          push_op_o.value = {1'b0, wake_rel};
        end
      end
      CMD_UNTIL: begin
        if (neg || (amount < count_q) || !slot_ok) begin
          push_op_o.value = REJECT_VALUE;
        end else begin
          push_op_o.kind  = OP_ARM;
          push_op_o.value = {1'b0, amount};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

FILE: rtl/tdwq_queue.sv
// Short operation queue between the front and back ends.
// Depends on tdwq_pkg.
`timescale 1ns / 1ps

module tdwq_queue import tdwq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  op_t  push_op_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output op_t  pop_op_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  op_t             slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            do_push, do_pop;

  assign push_ready_o = (fill_q != CntW'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_op_o     = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

FILE: rtl/tdwq_back.sv
// Back end: executes operations from the queue, keeps the pending flags and
// the wake time memory, scans slots on a tick and sends replies.
// Depends on tdwq_pkg and tdwq_ram.
`timescale 1ns / 1ps

module tdwq_back import tdwq_pkg::*; #(
  parameter int TASK_SLOTS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       op_valid_i,
  output logic       op_ready_o,
  input  op_t        op_i,
  tdwq_rsp_if.source rsp_o
);

  localparam int NumSlots = (TASK_SLOTS < MAX_SLOTS) ? TASK_SLOTS : MAX_SLOTS;
  localparam int IdxW     = $clog2(NumSlots);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumSlots - 1);

  bstate_e state_q, state_d;

  logic [NumSlots-1:0] waiting_q, waiting_d;
  logic [NumSlots-1:0] early_q, early_d;
  logic [NumSlots-1:0] late_q, late_d;
  logic [IdxW-1:0]     rd_idx_q, rd_idx_d;
  logic                rd_active_q, rd_active_d;
  logic [IdxW-1:0]     chk_idx_q, chk_idx_d;
  logic                chk_valid_q, chk_valid_d;
  logic [COUNT_W-1:0]  new_q, new_d;
  logic [COUNT_W-1:0]  old_q, old_d;
  logic [TASK_W-1:0]   sender_q, sender_d;
  logic                sender_pend_q, sender_pend_d;

  logic                out_valid_q, out_valid_d;
  logic [TASK_W-1:0]   out_task_q, out_task_d;
  logic [VALUE_W-1:0]  out_value_q, out_value_d;
  logic                out_last_q, out_last_d;

  logic                we;
  logic [IdxW-1:0]     waddr;
  logic [COUNT_W-1:0]  wdata;
  logic [COUNT_W-1:0]  rdata;

  logic                out_free;
  logic [IdxW-1:0]     early_idx, late_idx;
  logic [NumSlots-1:0] early_rest, late_rest;
  logic                emit_done;
  logic                scan_done;

  tdwq_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(NumSlots)
  ) u_wake_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rd_idx_q),
    .rdata_o(rdata)
  );

  assign out_free   = !out_valid_q || rsp_o.ready;
  assign early_rest = early_q & (early_q - NumSlots'(1));
  assign late_rest  = late_q & (late_q - NumSlots'(1));
  assign scan_done  = chk_valid_q && (chk_idx_q == LastIdx);

  // Lowest set bit of each release mask.
  always_comb begin
    early_idx = '0;
    late_idx  = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (early_q[i]) early_idx = IdxW'(i);
      if (late_q[i])  late_idx  = IdxW'(i);
    end
  end

  // The emitted reply is the last of the run once nothing remains behind it.
  always_comb begin
    emit_done = 1'b0;
    if (out_free) begin
      if (sender_pend_q) begin
        emit_done = (early_q == '0) && (late_q == '0);
      end else if (early_q != '0) begin
        emit_done = (early_rest == '0) && (late_q == '0);
      end else begin
        emit_done = (late_rest == '0);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: begin
        if (op_valid_i && (op_i.kind == OP_TICK)) state_d = BS_SCAN;
      end
      BS_SCAN: begin
        if (scan_done) state_d = BS_EMIT;
      end
      BS_EMIT: begin
        if (emit_done) state_d = BS_IDLE;
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_comb begin
    waiting_d     = waiting_q;
    early_d       = early_q;
    late_d        = late_q;
    rd_idx_d      = rd_idx_q;
    rd_active_d   = rd_active_q;
    chk_idx_d     = chk_idx_q;
    chk_valid_d   = 1'b0;
    new_d         = new_q;
    old_d         = old_q;
    sender_d      = sender_q;
    sender_pend_d = sender_pend_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_task_d    = out_task_q;
    out_value_d   = out_value_q;
    out_last_d    = out_last_q;
    op_ready_o    = 1'b0;
    we            = 1'b0;
    waddr         = op_i.slot[IdxW-1:0];
    wdata         = op_i.value[COUNT_W-1:0];

    unique case (state_q)
      BS_IDLE: begin
        if (op_valid_i) begin
          unique case (op_i.kind)
            OP_REPLY: begin
              if (out_free) begin
                op_ready_o  = 1'b1;
                out_valid_d = 1'b1;
                out_task_d  = op_i.slot;
                out_value_d = op_i.value;
                out_last_d  = 1'b1;
              end
            end
            OP_ARM: begin
              op_ready_o = 1'b1;
              we         = 1'b1;
              waiting_d[op_i.slot[IdxW-1:0]] = 1'b1;
            end
            OP_TICK: begin
              op_ready_o    = 1'b1;
              new_d         = op_i.value[COUNT_W-1:0];
              old_d         = op_i.aux;
              sender_d      = op_i.slot;
              sender_pend_d = 1'b1;
              early_d       = '0;
              late_d        = '0;
              rd_idx_d      = '0;
              rd_active_d   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      BS_SCAN: begin
        chk_valid_d = rd_active_q;
        chk_idx_d   = rd_idx_q;
        if (rd_active_q) begin
          if (rd_idx_q == LastIdx) begin
            rd_active_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + IdxW'(1);
          end
        end
        // Pending wake times never lie below the count before the tick, so a
        // release is due exactly when the wake time equals the old or new count.
        if (chk_valid_q && waiting_q[chk_idx_q]) begin
          if (rdata == old_q) begin
            early_d[chk_idx_q] = 1'b1;
          end else if (rdata == new_q) begin
            late_d[chk_idx_q] = 1'b1;
          end
        end
      end
      BS_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = {1'b0, new_q};
          out_last_d  = emit_done;
          if (sender_pend_q) begin
            out_task_d    = sender_q;
            sender_pend_d = 1'b0;
          end else if (early_q != '0) begin
            out_task_d           = TASK_W'(early_idx);
            early_d              = early_rest;
            waiting_d[early_idx] = 1'b0;
          end else begin
            out_task_d          = TASK_W'(late_idx);
            late_d              = late_rest;
            waiting_d[late_idx] = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= BS_IDLE;
      waiting_q     <= '0;
      early_q       <= '0;
      late_q        <= '0;
      rd_idx_q      <= '0;
      rd_active_q   <= 1'b0;
      chk_idx_q     <= '0;
      chk_valid_q   <= 1'b0;
      sender_pend_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      waiting_q     <= waiting_d;
      early_q       <= early_d;
      late_q        <= late_d;
      rd_idx_q      <= rd_idx_d;
      rd_active_q   <= rd_active_d;
      chk_idx_q     <= chk_idx_d;
      chk_valid_q   <= chk_valid_d;
      sender_pend_q <= sender_pend_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q       <= new_d;
    old_q       <= old_d;
    sender_q    <= sender_d;
    out_task_q  <= out_task_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.reply_task  = out_task_q;
  assign rsp_o.reply_value = out_value_q;
  assign rsp_o.last_of_run = out_last_q;

endmodule

FILE: dv/tick_delay_wakeup_queue_unit_tb.sv
// Self-checking testbench for the tick delay wakeup queue top level.
// Depends on tdwq_pkg, tdwq_cmd_if, tdwq_rsp_if and tick_delay_wakeup_queue_unit.
`timescale 1ns / 1ps

module tick_delay_wakeup_queue_unit_tb;
  import tdwq_pkg::*;

  // The block is built with the full set of task slots that the 5-bit
  // requester field can address.
  localparam int SLOTS = 32;

  // Requests per idling phase, its opening pass over all slots included; four phases give 408.
  localparam int PHASE_REQUESTS = 102;

  // One reply as the predictor expects it on the reply channel.
  typedef struct {
    logic [TASK_W-1:0]  dest;
    logic [VALUE_W-1:0] value;
    logic               last;
  } reply_t;

  // The scoreboard keeps its own copy of the tick count, the wake times and
  // the pending flags. Each accepted request is played against that copy and
  // the replies it causes are queued in order; each reply seen on the output
  // must match the oldest queued one.
  class wakeup_reply_board;
    logic [COUNT_W-1:0] ticks_now;
    logic [COUNT_W-1:0] slot_wake [SLOTS];
    bit                 slot_armed [SLOTS];
    reply_t             replies_due [$];
    int mismatches, checked, released, ticks, reads, armed, rejected;

    function new();
      ticks_now = '0;
      foreach (slot_wake[i]) begin
        slot_wake[i]  = '0;
        slot_armed[i] = 1'b0;
      end
      mismatches = 0;
      checked    = 0;
      released   = 0;
      ticks      = 0;
      reads      = 0;
      armed      = 0;
      rejected   = 0;
    endfunction

    function void queue_reply(logic [TASK_W-1:0] dest, logic [VALUE_W-1:0] value);
      reply_t r;
      r.dest  = dest;
      r.value = value;
      r.last  = 1'b0;
      replies_due.push_back(r);
    endfunction

    function void note_request(cmd_e op, logic [TASK_W-1:0] who,
                               logic [VALUE_W-1:0] amount);
      int                 before_cnt;
      int                 best;
      logic [VALUE_W-1:0] sum;
      before_cnt = replies_due.size();
      case (op)
        CMD_TICK: begin
          ticks++;
          // The count sticks at its maximum instead of wrapping.
          if (ticks_now != COUNT_MAX) ticks_now = ticks_now + 1'b1;
          queue_reply(who, {1'b0, ticks_now});
          // Release due slots earliest wake time first; equal wake times go
          // by ascending slot number.
          do begin
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_armed[i] && slot_wake[i] <= ticks_now &&
                  (best < 0 || slot_wake[i] < slot_wake[best])) best = i;
            end
            if (best >= 0) begin
              slot_armed[best] = 1'b0;
              slot_wake[best]  = '0;
              released++;
              queue_reply(TASK_W'(best), {1'b0, ticks_now});
            end
          end while (best >= 0);
        end
        CMD_READ: begin
          reads++;
          queue_reply(who, {1'b0, ticks_now});
        end
        CMD_DELAY: begin
          if (amount[VALUE_W-1] || int'(who) >= SLOTS) begin
            rejected++;
            queue_reply(who, REJECT_VALUE);
          end else begin
            // Both terms are below 2**31, so the sum fits and only needs
            // clamping to the largest count.
            sum = {1'b0, ticks_now} + amount;
            if (sum > {1'b0, COUNT_MAX}) sum = {1'b0, COUNT_MAX};
            armed++;
            slot_wake[who]  = sum[COUNT_W-1:0];
            slot_armed[who] = 1'b1;
          end
        end
        default: begin
          if (amount[VALUE_W-1] || amount < {1'b0, ticks_now} || int'(who) >= SLOTS) begin
            rejected++;
            queue_reply(who, REJECT_VALUE);
          end else begin
            armed++;
            slot_wake[who]  = amount[COUNT_W-1:0];
            slot_armed[who] = 1'b1;
          end
        end
      endcase
      if (replies_due.size() > before_cnt) replies_due[replies_due.size()-1].last = 1'b1;
    endfunction

    function void check_reply(logic [TASK_W-1:0] dest, logic [VALUE_W-1:0] value,
                              logic last);
      reply_t want;
      checked++;
      if (replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected reply, slot %0d value %0d last %0b",
                 $time, dest, $signed(value), last);
      end else begin
        want = replies_due.pop_front();
        if (dest !== want.dest) begin
          mismatches++;
          $display("%0t: reply_task expected %0d, got %0d", $time, want.dest, dest);
        end
        if (value !== want.value) begin
          mismatches++;
          $display("%0t: reply_value expected %0d, got %0d", $time,
                   $signed(want.value), $signed(value));
        end
        if (last !== want.last) begin
          mismatches++;
          $display("%0t: last_of_run expected %0b, got %0b", $time, want.last, last);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  tdwq_cmd_if cmd_if ();
  tdwq_rsp_if rsp_if ();

  tick_delay_wakeup_queue_unit #(
    .TASK_SLOTS(SLOTS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  wakeup_reply_board board = new();

  // Idling percentages of the current phase, for the request sender and the
  // reply receiver.
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int requests_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver decides afresh at every edge whether it takes a reply.
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Replies are sampled at the edge that accepts them, so the values seen are
  // those that stood before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      board.check_reply(rsp_if.reply_task, rsp_if.reply_value, rsp_if.last_of_run);
    end
  end

  // Offers one request, after a random number of idle cycles, and holds it
  // until the block takes it. Valid is left high after acceptance; the next
  // call either lowers it for a gap or drives the next request straight away.
  task automatic send_request(cmd_e op, logic [TASK_W-1:0] who, logic [VALUE_W-1:0] amount);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.command     <= op;
    cmd_if.requester   <= who;
    cmd_if.tick_amount <= amount;
    do @(posedge clk_i); while (!cmd_if.ready);
    board.note_request(op, who, amount);
    requests_sent++;
  endtask

  // Arms every slot with a short delay and then ticks until all are due.
  // With a top delay of zero the first tick releases all slots at once and
  // yields the longest possible run of replies.
  task automatic arm_every_slot(int top_delay);
    for (int s = 0; s < SLOTS; s++) begin
      send_request(CMD_DELAY, TASK_W'(s), VALUE_W'($urandom_range(0, top_delay)));
    end
    for (int k = 0; k <= top_delay; k++) begin
      send_request(CMD_TICK, TASK_W'($urandom_range(0, SLOTS - 1)), VALUE_W'($urandom));
    end
  endtask

  // Mostly well-formed traffic: short delays and near targets that ticks
  // soon release, with targets aimed just into the past now and then and a
  // share of fully random requests that reach every bit of every field.
  task automatic random_request();
    int                 pick;
    logic [TASK_W-1:0]  who;
    logic [VALUE_W-1:0] amount;
    pick = $urandom_range(0, 99);
    who  = TASK_W'($urandom_range(0, SLOTS - 1));
    if (pick < 30) begin
      send_request(CMD_DELAY, who, VALUE_W'($urandom_range(0, 12)));
    end else if (pick < 45) begin
      amount = {1'b0, board.ticks_now} + VALUE_W'($urandom_range(0, 12));
      if ($urandom_range(0, 4) == 0) amount = amount - VALUE_W'($urandom_range(1, 14));
      send_request(CMD_UNTIL, who, amount);
    end else if (pick < 75) begin
      send_request(CMD_TICK, who, VALUE_W'($urandom));
    end else if (pick < 85) begin
      send_request(CMD_READ, who, VALUE_W'($urandom));
    end else begin
      send_request(cmd_e'($urandom_range(0, 3)), who, VALUE_W'($urandom));
    end
  endtask

  initial begin
    int phase_start;
    rst_ni             <= 1'b0;
    cmd_if.valid       <= 1'b0;
    cmd_if.command     <= CMD_TICK;
    cmd_if.requester   <= '0;
    cmd_if.tick_amount <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, without idling. The saturated count itself lies 2**31 - 1
    // ticks away and cannot be reached here; saturation of the wake time is
    // covered instead.
    send_request(CMD_READ,  5'd0,  32'd0);           // count still zero after reset
    send_request(CMD_TICK,  5'd7,  32'hFFFF_FFFF);   // sender gets the new count
    send_request(CMD_DELAY, 5'd4,  32'h7FFF_FFFF);   // wake time clamps at the maximum
    send_request(CMD_UNTIL, 5'd3,  32'd1);           // target equal to the count
    send_request(CMD_DELAY, 5'd1,  32'd0);           // zero delay, due on the next tick
    send_request(CMD_UNTIL, 5'd5,  32'd0);           // target in the past
    send_request(CMD_UNTIL, 5'd6,  32'h8000_0000);   // negative target
    send_request(CMD_DELAY, 5'd2,  32'hFFFF_FFFF);   // negative delay
    send_request(CMD_DELAY, 5'd9,  32'd5);
    send_request(CMD_DELAY, 5'd9,  32'd1);           // repeat request overwrites the slot
    send_request(CMD_DELAY, 5'd8,  32'd1);
    send_request(CMD_UNTIL, 5'd0,  32'd2);           // three-way tie on wake time two
    send_request(CMD_TICK,  5'd31, 32'd0);           // releases slots 1, 3, then 0, 8, 9
    send_request(CMD_UNTIL, 5'd10, 32'h7FFF_FFFF);   // largest absolute target
    send_request(CMD_READ,  5'd31, 32'h8000_0000);
    send_request(CMD_TICK,  5'd0,  32'h7FFF_FFFF);
    send_request(CMD_DELAY, 5'd4,  32'd3);           // replaces the saturated wake time
    send_request(CMD_UNTIL, 5'd11, 32'd4);
    send_request(CMD_DELAY, 5'd12, 32'd1);           // same wake time as slot 11, released after it by slot number
    send_request(CMD_TICK,  5'd5,  32'd0);
    send_request(CMD_TICK,  5'd6,  32'd0);
    send_request(CMD_TICK,  5'd2,  32'd0);

    // Random part in four idling phases; each opens with a pass over all slots.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 49;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 49;
        end
        default: begin
          src_idle_pct  = 25;
          snk_stall_pct = 25;
        end
      endcase
      phase_start = requests_sent;
      arm_every_slot(phase == 0 ? 0 : $urandom_range(0, 3));
      while (requests_sent - phase_start < PHASE_REQUESTS) random_request();
    end
    cmd_if.valid <= 1'b0;

    // Drain, then allow for a full scan and run of replies that should not come.
    while (board.replies_due.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("Sent %0d requests: %0d ticks, %0d reads, %0d delays armed, %0d rejected.",
             requests_sent, board.ticks, board.reads, board.armed, board.rejected);
    $display("Checked %0d replies, %0d of them slot releases; final count %0d.",
             board.checked, board.released, board.ticks_now);
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
